// ===== design/mqttrx_pkg.sv =====
`default_nettype none
package mqttrx_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] packet_id;
        logic        last;
    } res_item_t;

    // one request's worth of results: optional lead result, transmit burst, closing result
    typedef struct packed {
        logic        a_vld;
        logic [2:0]  a_kind;
        logic [7:0]  a_data;
        logic [15:0] a_pid;
        logic [2:0]  tx_n;
        logic [7:0]  tx_b0;
        logic [7:0]  tx_b1;
        logic [15:0] tx_id;
        logic        b_vld;
        logic [2:0]  b_kind;
        logic [7:0]  b_data;
        logic [15:0] b_pid;
    } job_t;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_LEN1,
        PH_LEN2,
        PH_BODY
    } phase_t;

    localparam logic [1:0] CMD_RX      = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [2:0] KIND_TOPIC     = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
    localparam logic [2:0] KIND_DONE      = 3'd2;
    localparam logic [2:0] KIND_CONNACK   = 3'd3;
    localparam logic [2:0] KIND_TX        = 3'd4;
    localparam logic [2:0] KIND_LEN_ERR   = 3'd5;
    localparam logic [2:0] KIND_MALFORMED = 3'd6;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd7;

    localparam logic [3:0] TYPE_RSVD0      = 4'd0;
    localparam logic [3:0] TYPE_CONNACK    = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH    = 4'd3;
    localparam logic [3:0] TYPE_PUBREC     = 4'd5;
    localparam logic [3:0] TYPE_PUBCOMP    = 4'd7;
    localparam logic [3:0] TYPE_DISCONNECT = 4'd14;
    localparam logic [3:0] TYPE_RSVD15     = 4'd15;

    localparam logic [7:0] PKT_PUBACK  = 8'h40;
    localparam logic [7:0] PKT_PUBREC  = 8'h50;
    localparam logic [7:0] PKT_PUBREL  = 8'h62;
    localparam logic [7:0] PKT_PINGREQ = 8'hC0;
    localparam logic [7:0] ACK_LEN     = 8'h02;
    localparam logic [7:0] PING_LEN    = 8'h00;

    localparam logic [2:0]  TX_PING    = 3'd2;
    localparam logic [2:0]  TX_ACK     = 3'd4;
    localparam logic [15:0] KA_DEFAULT = 16'd60;
    localparam logic [2:0]  JOB_MAX    = 3'd5;

endpackage
`default_nettype wire

// ===== design/mqttrx_front.sv =====
`default_nettype none
module mqttrx_front
    import mqttrx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        accept,
    input  wire in_item_t    item,
    output logic             push,
    output job_t             job
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  header_reg, header_next;
    logic [13:0] rem_reg, rem_next;
    logic [13:0] body_reg, body_next;
    logic [15:0] topic_reg, topic_next;
    logic [15:0] id_reg, id_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] now_inc_reg, now_inc_next;
    logic [31:0] deadline_reg, deadline_next;
    logic        conn_reg, conn_next;
    logic        dead_reg, dead_next;
    logic [15:0] ka_reg;

    logic [3:0]  hdr_type;
    logic        qos_any;
    logic [13:0] body_inc;
    logic [13:0] pub_t;
    logic        body_done;
    logic [13:0] len_short;
    logic [13:0] len_long;
    logic [7:0]  rxb;

    logic [15:0] topic_upd;
    logic [15:0] id_upd;
    logic        pa_vld;
    logic [2:0]  pa_kind;
    logic [15:0] pa_pid;
    logic        pack;

    logic        start_go;
    logic [13:0] start_len;
    logic        fin_go;
    logic [13:0] fin_body;
    logic [15:0] fin_topic;
    logic [15:0] fin_id;
    logic [17:0] fin_need;
    logic        refresh;
    logic [31:0] refresh_base;
    logic [15:0] ka_eff;

    assign rxb       = item.rx_byte;
    assign hdr_type  = header_reg[7:4];
    assign qos_any   = |header_reg[2:1];
    assign body_inc  = body_reg + 14'd1;
    assign pub_t     = body_reg - 14'd2;
    assign body_done = body_inc >= rem_reg;
    assign len_short = {7'd0, rxb[6:0]};
    assign len_long  = {rxb[6:0], rem_reg[6:0]};
    assign ka_eff    = (ka_reg == 16'd0) ? KA_DEFAULT : ka_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (item.cmd)
                CMD_RX:
                begin
                    if (!dead_reg)
                    begin
                        case (phase_reg)
                            PH_HDR:  phase_next = PH_LEN1;
                            PH_LEN1:
                            begin
                                if (rxb[7])
                                    phase_next = PH_LEN2;
                                else if (len_short == 14'd0)
                                    phase_next = PH_HDR;
                                else
                                    phase_next = PH_BODY;
                            end
                            PH_LEN2:
                            begin
                                if (rxb[7] || len_long == 14'd0)
                                    phase_next = PH_HDR;
                                else
                                    phase_next = PH_BODY;
                            end
                            PH_BODY:
                            begin
                                if (body_done)
                                    phase_next = PH_HDR;
                            end
                            default: phase_next = PH_HDR;
                        endcase
                    end
                end
                CMD_RESTART: phase_next = PH_HDR;
                default: phase_next = phase_reg;
            endcase
        end
    end

    // body byte of a publish or pubrec
    always_comb
    begin
        topic_upd = topic_reg;
        id_upd    = id_reg;
        pa_vld    = 1'b0;
        pa_kind   = KIND_TOPIC;
        pa_pid    = 16'd0;
        pack      = 1'b0;
        case (hdr_type)
            TYPE_PUBLISH:
            begin
                if (body_reg == 14'd0)
                    topic_upd = {rxb, 8'h00};
                else if (body_reg == 14'd1)
                    topic_upd = topic_reg | {8'h00, rxb};
                else if ({2'b00, pub_t} < topic_reg)
                    pa_vld = 1'b1;
                else if (qos_any && ({3'b000, pub_t} < ({1'b0, topic_reg} + 17'd2)))
                begin
                    if ({2'b00, pub_t} == topic_reg)
                        id_upd = {rxb, 8'h00};
                    else
                    begin
                        id_upd = id_reg | {8'h00, rxb};
                        pack   = 1'b1;
                    end
                end
                else
                begin
                    pa_vld  = 1'b1;
                    pa_kind = KIND_PAYLOAD;
                    pa_pid  = id_reg;
                end
            end
            TYPE_PUBREC:
            begin
                if (body_reg == 14'd0)
                    id_upd = {rxb, id_reg[7:0]};
                else if (body_reg == 14'd1)
                    id_upd = {id_reg[15:8], rxb};
            end
            default: ;
        endcase
    end

    assign fin_need = {2'b00, fin_topic} + 18'd2 + (qos_any ? 18'd2 : 18'd0);

    // state update and result job
    always_comb
    begin
        header_next   = header_reg;
        rem_next      = rem_reg;
        body_next     = body_reg;
        topic_next    = topic_reg;
        id_next       = id_reg;
        now_next      = now_reg;
        now_inc_next  = now_inc_reg;
        deadline_next = deadline_reg;
        conn_next     = conn_reg;
        dead_next     = dead_reg;
        job           = '0;
        start_go      = 1'b0;
        start_len     = 14'd0;
        fin_go        = 1'b0;
        fin_body      = body_inc;
        fin_topic     = topic_upd;
        fin_id        = id_upd;
        refresh       = 1'b0;
        refresh_base  = now_reg;

        if (accept)
        begin
            case (item.cmd)
                CMD_RX:
                begin
                    if (!dead_reg)
                    begin
                        case (phase_reg)
                            PH_HDR: header_next = rxb;
                            PH_LEN1:
                            begin
                                if (rxb[7])
                                    rem_next = len_short;
                                else
                                begin
                                    start_go  = 1'b1;
                                    start_len = len_short;
                                end
                            end
                            PH_LEN2:
                            begin
                                if (rxb[7])
                                begin
                                    job.b_vld  = 1'b1;
                                    job.b_kind = KIND_LEN_ERR;
                                    conn_next  = 1'b0;
                                    dead_next  = 1'b1;
                                end
                                else
                                begin
                                    start_go  = 1'b1;
                                    start_len = len_long;
                                end
                            end
                            PH_BODY:
                            begin
                                body_next  = body_inc;
                                topic_next = topic_upd;
                                id_next    = id_upd;
                                job.a_vld  = pa_vld;
                                job.a_kind = pa_kind;
                                job.a_data = rxb;
                                job.a_pid  = pa_pid;
                                if (pack)
                                begin
                                    job.tx_n  = TX_ACK;
                                    job.tx_b0 = header_reg[2] ? PKT_PUBREC : PKT_PUBACK;
                                    job.tx_b1 = ACK_LEN;
                                    job.tx_id = id_upd;
                                end
                                fin_go = body_done;
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_TICK:
                begin
                    now_next     = now_inc_reg;
                    now_inc_next = now_inc_reg + 32'd1;
                    refresh_base = now_inc_reg;
                    if (!dead_reg && now_inc_reg >= deadline_reg)
                    begin
                        job.tx_n  = TX_PING;
                        job.tx_b0 = PKT_PINGREQ;
                        job.tx_b1 = PING_LEN;
                    end
                end
                CMD_RESTART:
                begin
                    header_next = 8'h00;
                    rem_next    = 14'd0;
                    body_next   = 14'd0;
                    topic_next  = 16'd0;
                    id_next     = 16'd0;
                    conn_next   = 1'b0;
                    dead_next   = 1'b0;
                    refresh     = 1'b1;
                end
                default: ;
            endcase
        end

        if (start_go)
        begin
            rem_next   = start_len;
            body_next  = 14'd0;
            topic_next = 16'd0;
            id_next    = 16'd0;
            fin_go     = (start_len == 14'd0);
            fin_body   = 14'd0;
            fin_topic  = 16'd0;
            fin_id     = 16'd0;
        end

        if (fin_go)
        begin
            case (hdr_type)
                TYPE_CONNACK:
                begin
                    job.b_vld  = 1'b1;
                    job.b_kind = KIND_CONNACK;
                    conn_next  = 1'b1;
                end
                TYPE_PUBLISH:
                begin
                    job.b_vld = 1'b1;
                    if (fin_body >= 14'd2 && {4'd0, fin_body} >= fin_need)
                    begin
                        job.b_kind = KIND_DONE;
                        job.b_pid  = fin_id;
                    end
                    else
                        job.b_kind = KIND_MALFORMED;
                end
                TYPE_PUBREC:
                begin
                    job.tx_n  = TX_ACK;
                    job.tx_b0 = PKT_PUBREL;
                    job.tx_b1 = ACK_LEN;
                    job.tx_id = fin_id;
                end
                TYPE_RSVD0, TYPE_PUBCOMP, TYPE_DISCONNECT, TYPE_RSVD15:
                begin
                    job.b_vld  = 1'b1;
                    job.b_kind = KIND_UNKNOWN;
                    job.b_data = {4'd0, hdr_type};
                end
                default: ;
            endcase
        end

        if (job.tx_n != 3'd0)
            refresh = 1'b1;
        if (refresh)
            deadline_next = refresh_base + {16'd0, ka_eff};
    end

    assign push = accept && (job.a_vld || job.b_vld || job.tx_n != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR;
            header_reg   <= 8'h00;
            rem_reg      <= 14'd0;
            body_reg     <= 14'd0;
            topic_reg    <= 16'd0;
            id_reg       <= 16'd0;
            now_reg      <= 32'd1;
            now_inc_reg  <= 32'd2;
            deadline_reg <= 32'd61;
            conn_reg     <= 1'b0;
            dead_reg     <= 1'b0;
            ka_reg       <= KA_DEFAULT;
        end
        else
        begin
            phase_reg    <= phase_next;
            header_reg   <= header_next;
            rem_reg      <= rem_next;
            body_reg     <= body_next;
            topic_reg    <= topic_next;
            id_reg       <= id_next;
            now_reg      <= now_next;
            now_inc_reg  <= now_inc_next;
            deadline_reg <= deadline_next;
            conn_reg     <= conn_next;
            dead_reg     <= dead_next;
            if (cfg_wr_en)
                ka_reg <= cfg_wr_data;
        end
    end

`ifndef SYNTH
    // a dead link neither frames nor pings
    a_dead_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |-> !push)
        else $error("result pushed on dead link");
`endif

endmodule
`default_nettype wire

// ===== design/mqttrx_fifo.sv =====
`default_nettype none
module mqttrx_fifo
    import mqttrx_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output logic      empty,
    output logic      full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== design/mqttrx_back.sv =====
`default_nettype none
module mqttrx_back
    import mqttrx_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t head_job,
    input  wire logic empty,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output res_item_t out_item
);

    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    res_item_t  out_item_reg;

    logic [2:0] n_a;
    logic [2:0] tx_end;
    logic [2:0] total;
    logic [1:0] tx_k;
    logic       load;
    logic       item_last;
    res_item_t  item;

    assign n_a       = {2'b00, head_job.a_vld};
    assign tx_end    = n_a + head_job.tx_n;
    assign total     = tx_end + {2'b00, head_job.b_vld};
    assign tx_k      = 2'(step_reg - n_a);
    assign item_last = (step_reg == total - 3'd1);
    assign load      = !empty && (!out_valid_reg || !out_stall);
    assign pop       = load && item_last;

    // pick the result at the current step of the head request
    always_comb
    begin
        item.last = item_last;
        if (step_reg < n_a)
        begin
            item.kind      = head_job.a_kind;
            item.data      = head_job.a_data;
            item.packet_id = head_job.a_pid;
        end
        else if (step_reg < tx_end)
        begin
            item.kind      = KIND_TX;
            item.packet_id = 16'd0;
            case (tx_k)
                2'd0:    item.data = head_job.tx_b0;
                2'd1:    item.data = head_job.tx_b1;
                2'd2:    item.data = head_job.tx_id[15:8];
                default: item.data = head_job.tx_id[7:0];
            endcase
        end
        else
        begin
            item.kind      = head_job.b_kind;
            item.data      = head_job.b_data;
            item.packet_id = head_job.b_pid;
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = item_last ? 3'd0 : step_reg + 3'd1;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (step_reg < total && total <= JOB_MAX))
        else $error("step outside request");
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && out_item_reg.last))
        else $error("request retired without last result");
`endif

endmodule
`default_nettype wire

// ===== design/mqtt_rx_framer_keepalive_top.sv =====
// path: a request is queued, then its results are loaded into the output register
// throughput: one request per cycle enters while the queue has room; results leave
// one per cycle through the single output register while not stalled, so a request
// causing up to 5 results holds the output until the last of them has left
// reset: async active low; framing idle, link alive and unconnected, keepalive 60,
// clock at one second with the first ping due at 61
`default_nettype none
module mqtt_rx_framer_keepalive_top
    import mqttrx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output res_item_t        out_item
);

    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    job_t push_job;
    job_t head_job;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    mqttrx_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (in_item),
        .push        (push),
        .job         (push_job)
    );

    mqttrx_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    mqttrx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire
